/* sv/bayer_bilinear_demosaic_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Bayer demosaic block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BAYER_BILINEAR_DEMOSAIC_TOP_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BBD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBD_ASSERT_IMP(lbl, ante, cons, msg)
`define BBD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/bbd_pkg.sv */
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants, codes and the control bundle between pipeline stages.
// ----------------------------------------------------------------------------
package bbd_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;

	localparam int unsigned DIM_BITS   = 11;
	localparam int unsigned PIXEL_BITS = 8;
	localparam int unsigned RGB_BITS   = 3 * PIXEL_BITS;

	localparam int unsigned APB_ADDR_BITS = 3;
	localparam int unsigned APB_DATA_BITS = 32;

	localparam logic [DIM_BITS-1:0] RESET_WIDTH  = DIM_BITS'(32);
	localparam logic [DIM_BITS-1:0] RESET_HEIGHT = DIM_BITS'(32);

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic emit;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic odd_row;
		logic odd_col;
		logic frame_end;
	} bbd_flags_t;

endpackage

/* sv/bbd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB write and read of the image width and height, clamped for the datapath.
// ----------------------------------------------------------------------------
module bbd_cfg_regs import bbd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [WW-1:0]            width,
	output logic [HW-1:0]            height,
	output logic                     cfg_clear
);

	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic                reg_sel;

	function automatic logic [31:0] clamp_dim(logic [DIM_BITS-1:0] v, int unsigned hi);
		logic [31:0] ext;
		ext = 32'(v);
		if (ext < 32'd2) begin
			return 32'd2;
		end
		if (ext > 32'(hi)) begin
			return 32'(hi);
		end
		return ext;
	endfunction

	assign pready    = 1'b1;
	assign reg_sel   = paddr[APB_ADDR_BITS-1];
	assign cfg_clear = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_clear) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = APB_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = APB_DATA_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign width  = WW'(clamp_dim(width_q, MAX_WIDTH));
	assign height = HW'(clamp_dim(height_q, MAX_HEIGHT));

endmodule

/* sv/bbd_ctrl.sv */
// ----------------------------------------------------------------------------
// Position control and first pipeline stage
// Tracks input and output positions, issues line memory reads and loads s1.
// ----------------------------------------------------------------------------
module bbd_ctrl import bbd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int unsigned CW = $clog2(MAX_WIDTH),
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
	localparam int unsigned RW = $clog2(MAX_HEIGHT + 2),
	localparam int unsigned OW = $clog2(MAX_HEIGHT)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_clear,
	input  logic [WW-1:0]         width,
	input  logic [HW-1:0]         height,
	input  logic                  in_tvalid,
	output logic                  in_tready,
	input  logic                  in_cmd,
	input  logic [PIXEL_BITS-1:0] in_px,
	input  logic                  commit,
	output logic                  mem_ren,
	output logic [CW-1:0]         mem_raddr,
	output logic                  s1_valid,
	output logic [CW-1:0]         s1_ci,
	output logic [PIXEL_BITS-1:0] s1_px,
	output logic                  s1_fwd,
	output bbd_flags_t            s1_flags
);

	logic [CW-1:0]         in_col_q;
	logic [RW-1:0]         in_row_q;
	logic [CW-1:0]         out_col_q;
	logic [OW-1:0]         out_row_q;
	logic                  s1_valid_q;
	logic [CW-1:0]         ci_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic                  fwd_s1;
	bbd_flags_t            flags_s1;

	logic                  accept;
	logic                  draining;
	logic                  take;
	logic [WW-1:0]         col_inc;
	logic [WW-1:0]         ocol_inc;
	logic [HW-1:0]         orow_inc;
	logic                  col_wrap;
	bbd_flags_t            flags;

	assign in_tready = !s1_valid_q || commit;
	assign accept    = in_tvalid && in_tready;
	assign draining  = in_row_q >= RW'(height);
	assign take      = accept && (draining || in_cmd == CMD_PIXEL);

	assign col_inc  = WW'(in_col_q) + WW'(1);
	assign ocol_inc = WW'(out_col_q) + WW'(1);
	assign orow_inc = HW'(out_row_q) + HW'(1);
	assign col_wrap = col_inc >= width;

	always_comb begin
		flags.emit      = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
		flags.top       = out_row_q == '0;
		flags.bottom    = orow_inc >= height;
		flags.left      = out_col_q == '0;
		flags.right     = ocol_inc >= width;
		flags.odd_row   = out_row_q[0];
		flags.odd_col   = out_col_q[0];
		flags.frame_end = flags.bottom && flags.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_clear) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (flags.emit && flags.frame_end) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= CW'(col_inc);
				end
				if (flags.emit) begin
					if (flags.right) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + OW'(1);
					end else begin
						out_col_q <= CW'(ocol_inc);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	// The column just written back by s1 is read again by the new request
	// only when a frame restarts at column zero; that case is forwarded.
	always_ff @(posedge clk) begin
		if (take) begin
			ci_s1    <= in_col_q;
			px_s1    <= draining ? '0 : in_px;
			fwd_s1   <= s1_valid_q && ci_s1 == in_col_q;
			flags_s1 <= flags;
		end
	end

	assign mem_ren   = take;
	assign mem_raddr = in_col_q;
	assign s1_valid  = s1_valid_q;
	assign s1_ci     = ci_s1;
	assign s1_px     = px_s1;
	assign s1_fwd    = fwd_s1;
	assign s1_flags  = flags_s1;

endmodule

/* sv/bbd_line_mem.sv */
// ----------------------------------------------------------------------------
// Line memories
// Two one-row stores with a registered read port and a write port each.
// ----------------------------------------------------------------------------
module bbd_line_mem import bbd_pkg::*; #(
	parameter int unsigned DEPTH = MAX_WIDTH_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  ren,
	input  logic [AW-1:0]         raddr,
	output logic [PIXEL_BITS-1:0] rdata_a,
	output logic [PIXEL_BITS-1:0] rdata_b,
	input  logic                  wen,
	input  logic [AW-1:0]         waddr,
	input  logic [PIXEL_BITS-1:0] wdata_a,
	input  logic [PIXEL_BITS-1:0] wdata_b
);

	logic [PIXEL_BITS-1:0] mem_a [DEPTH];
	logic [PIXEL_BITS-1:0] mem_b [DEPTH];
	logic [PIXEL_BITS-1:0] rd_a_q;
	logic [PIXEL_BITS-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (ren) begin
			rd_a_q <= mem_a[raddr];
			rd_b_q <= mem_b[raddr];
		end
		if (wen) begin
			mem_a[waddr] <= wdata_a;
			mem_b[waddr] <= wdata_b;
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

/* sv/bbd_window.sv */
// ----------------------------------------------------------------------------
// Window and interpolation stage
// Shifts the 3x3 window, writes the line memories back and registers RGB.
// ----------------------------------------------------------------------------
module bbd_window import bbd_pkg::*; #(
	parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s1_valid,
	input  logic [CW-1:0]         s1_ci,
	input  logic [PIXEL_BITS-1:0] s1_px,
	input  logic                  s1_fwd,
	input  bbd_flags_t            s1_flags,
	input  logic [PIXEL_BITS-1:0] rd_a,
	input  logic [PIXEL_BITS-1:0] rd_b,
	output logic                  commit,
	output logic                  mem_wen,
	output logic [CW-1:0]         mem_waddr,
	output logic [PIXEL_BITS-1:0] mem_wdata_a,
	output logic [PIXEL_BITS-1:0] mem_wdata_b,
	output logic                  out_tvalid,
	input  logic                  out_tready,
	output logic [RGB_BITS-1:0]   out_tdata,
	output logic                  out_tlast
);

	logic [PIXEL_BITS-1:0] win_q [9];
	logic [PIXEL_BITS-1:0] nw [9];
	logic [PIXEL_BITS-1:0] last_px_q;
	logic [PIXEL_BITS-1:0] last_a_q;
	logic [PIXEL_BITS-1:0] a_eff;
	logic [PIXEL_BITS-1:0] b_eff;
	logic                  out_valid_q;
	logic [RGB_BITS-1:0]   out_data_q;
	logic                  out_last_q;

	logic [PIXEL_BITS-1:0] p11, p12, p13, p21, p22, p23, p31, p32, p33;
	logic [PIXEL_BITS:0]   horiz;
	logic [PIXEL_BITS:0]   vert;
	logic [PIXEL_BITS+1:0] cross_sum;
	logic [PIXEL_BITS+1:0] diag;
	logic [PIXEL_BITS-1:0] red, green, blue;
	logic                  load_out;

	assign commit   = s1_valid && (!s1_flags.emit || !out_valid_q || out_tready);
	assign load_out = commit && s1_flags.emit;

	assign a_eff = s1_fwd ? last_px_q : rd_a;
	assign b_eff = s1_fwd ? last_a_q  : rd_b;

	always_comb begin
		nw[0] = win_q[1];
		nw[1] = win_q[2];
		nw[2] = b_eff;
		nw[3] = win_q[4];
		nw[4] = win_q[5];
		nw[5] = a_eff;
		nw[6] = win_q[7];
		nw[7] = win_q[8];
		nw[8] = s1_px;
	end

	always_comb begin
		p11 = (s1_flags.top || s1_flags.left) ? '0 : nw[0];
		p12 = s1_flags.top ? '0 : nw[1];
		p13 = (s1_flags.top || s1_flags.right) ? '0 : nw[2];
		p21 = s1_flags.left ? '0 : nw[3];
		p22 = nw[4];
		p23 = s1_flags.right ? '0 : nw[5];
		p31 = (s1_flags.bottom || s1_flags.left) ? '0 : nw[6];
		p32 = s1_flags.bottom ? '0 : nw[7];
		p33 = (s1_flags.bottom || s1_flags.right) ? '0 : nw[8];

		horiz     = {1'b0, p21} + {1'b0, p23};
		vert      = {1'b0, p12} + {1'b0, p32};
		cross_sum = {2'b00, p12} + {2'b00, p21} + {2'b00, p23} + {2'b00, p32};
		diag      = {2'b00, p11} + {2'b00, p13} + {2'b00, p31} + {2'b00, p33};

		case ({s1_flags.odd_row, s1_flags.odd_col})
			2'b11: begin
				red   = horiz[PIXEL_BITS:1];
				green = p22;
				blue  = vert[PIXEL_BITS:1];
			end
			2'b00: begin
				red   = vert[PIXEL_BITS:1];
				green = p22;
				blue  = horiz[PIXEL_BITS:1];
			end
			2'b10: begin
				red   = p22;
				green = cross_sum[PIXEL_BITS+1:2];
				blue  = diag[PIXEL_BITS+1:2];
			end
			default: begin
				red   = diag[PIXEL_BITS+1:2];
				green = cross_sum[PIXEL_BITS+1:2];
				blue  = p22;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= nw[i];
			end
			last_px_q <= s1_px;
			last_a_q  <= a_eff;
		end
		if (load_out) begin
			out_data_q <= {blue, green, red};
			out_last_q <= s1_flags.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign mem_wen     = commit;
	assign mem_waddr   = s1_ci;
	assign mem_wdata_a = s1_px;
	assign mem_wdata_b = a_eff;

	assign out_tvalid = out_valid_q;
	assign out_tdata  = out_data_q;
	assign out_tlast  = out_last_q;

endmodule

/* sv/bayer_bilinear_demosaic_top.sv */
// ----------------------------------------------------------------------------
// Bilinear Bayer demosaic, 3x3 window
// Streaming Bayer to RGB converter with two line memories and an APB port.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, pixels and flush ticks alike,
// and gives one RGB pixel per image position. Each request is read from the
// line memories at the clock edge that accepts it and is written back when
// it leaves the pipeline stage s1, which is also when its result, if it has
// one, is loaded into the output register as the request commits. A
// new request is taken every cycle unless a result waits in the output
// register while the pipeline stage holds another request with a result; the
// input then stalls until the waiting result is taken. A result belongs to the
// position one row and one pixel behind the input, so after the last pixel
// of a frame, width plus one flush ticks drain the rest; flush ticks sent
// while pixels are still expected are dropped. Pixels outside the image count
// as zero. The line memories need no clearing after reset, since every tap
// that is not masked was written earlier in the same frame. Any register
// write restarts the frame and must be done while the block is idle.
// ----------------------------------------------------------------------------
`include "bayer_bilinear_demosaic_top_defines.svh"

module bayer_bilinear_demosaic_top import bbd_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [PIXEL_BITS-1:0]    s_axis_tdata,  // [7:0] bayer_pixel
	input  logic                     s_axis_tuser,  // [0] command
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [RGB_BITS-1:0]      m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
	output logic                     m_axis_tlast,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

	logic [WW-1:0]         width;
	logic [HW-1:0]         height;
	logic                  cfg_clear;
	logic                  commit;
	logic                  mem_ren;
	logic [CW-1:0]         mem_raddr;
	logic                  mem_wen;
	logic [CW-1:0]         mem_waddr;
	logic [PIXEL_BITS-1:0] mem_wdata_a;
	logic [PIXEL_BITS-1:0] mem_wdata_b;
	logic [PIXEL_BITS-1:0] rd_a;
	logic [PIXEL_BITS-1:0] rd_b;
	logic                  s1_valid;
	logic [CW-1:0]         s1_ci;
	logic [PIXEL_BITS-1:0] s1_px;
	logic                  s1_fwd;
	bbd_flags_t            s1_flags;

	bbd_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.width    (width),
		.height   (height),
		.cfg_clear(cfg_clear)
	);

	bbd_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_clear(cfg_clear),
		.width    (width),
		.height   (height),
		.in_tvalid(s_axis_tvalid),
		.in_tready(s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_px    (s_axis_tdata),
		.commit   (commit),
		.mem_ren  (mem_ren),
		.mem_raddr(mem_raddr),
		.s1_valid (s1_valid),
		.s1_ci    (s1_ci),
		.s1_px    (s1_px),
		.s1_fwd   (s1_fwd),
		.s1_flags (s1_flags)
	);

	bbd_line_mem #(
		.DEPTH(MAX_WIDTH)
	) u_mem (
		.clk    (clk),
		.ren    (mem_ren),
		.raddr  (mem_raddr),
		.rdata_a(rd_a),
		.rdata_b(rd_b),
		.wen    (mem_wen),
		.waddr  (mem_waddr),
		.wdata_a(mem_wdata_a),
		.wdata_b(mem_wdata_b)
	);

	bbd_window #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1_ci      (s1_ci),
		.s1_px      (s1_px),
		.s1_fwd     (s1_fwd),
		.s1_flags   (s1_flags),
		.rd_a       (rd_a),
		.rd_b       (rd_b),
		.commit     (commit),
		.mem_wen    (mem_wen),
		.mem_waddr  (mem_waddr),
		.mem_wdata_a(mem_wdata_a),
		.mem_wdata_b(mem_wdata_b),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata),
		.out_tlast  (m_axis_tlast)
	);

	`BBD_ASSERT_IMP(a_ready_only_on_stall, !s_axis_tready, s1_valid && m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")
	`BBD_ASSERT_NXT(a_same_column_forwarded, mem_ren && mem_wen && mem_waddr == mem_raddr, s1_fwd, "read of a column being written was not forwarded")
	`BBD_ASSERT_NXT(a_emit_reaches_output, commit && s1_flags.emit, m_axis_tvalid, "emitted pixel did not reach the output register")

endmodule
